[rtl/b64d_pkg.sv]
// Package with the types, codes and symbol lookup shared by the base64 decoder files.
`default_nettype none

package b64d_pkg;

   // Input action codes.
   localparam logic ACTION_CHAR = 1'b0;
   localparam logic ACTION_END  = 1'b1;

   // Result kind codes.
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // The padding character.
   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // Results queue geometry.
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_ADDR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

   // Most results that one transaction can cause.
   localparam int MAX_RESULTS = 3;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_TRUNCATED    = 2'd1,
      STATUS_PAD_ONE      = 2'd2,
      STATUS_PAD_BOUNDARY = 2'd3
   } status_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic [1:0] status;
      logic       last;
   } result_type;

   // All results of one input transaction; count holds 1 to MAX_RESULTS.
   typedef struct packed {
      logic [1:0]                   count;
      result_type [MAX_RESULTS-1:0] results;
   } bundle_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } symbol_type;

   // Maps a character to its 6-bit symbol value; valid is low outside the alphabet.
   function automatic symbol_type symbol_lookup(input logic [7:0] ch);
      symbol_type sym;
      sym.valid = 1'b1;
      sym.value = '0;
      if (ch inside {[8'h41:8'h5A]}) begin
         sym.value = 6'(ch - 8'h41);
      end else if (ch inside {[8'h61:8'h7A]}) begin
         sym.value = 6'(ch - 8'h61 + 8'd26);
      end else if (ch inside {[8'h30:8'h39]}) begin
         sym.value = 6'(ch - 8'h30 + 8'd52);
      end else if (ch == 8'h2B) begin
         sym.value = 6'd62;
      end else if (ch == 8'h2F) begin
         sym.value = 6'd63;
      end else begin
         sym.valid = 1'b0;
      end
      return sym;
   endfunction

   function automatic result_type data_result(input logic [7:0] value, input logic last);
      result_type r;
      r.kind      = KIND_DATA;
      r.data_byte = value;
      r.status    = STATUS_OK;
      r.last      = last;
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/b64d_if.sv]
// Valid/ready channel interfaces for the decoder's character input and result output.
`default_nettype none

interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] ch;

   modport source (output valid, output action, output ch, input ready);
   modport sink   (input valid, input action, input ch, output ready);
endinterface

interface b64d_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;
   logic [1:0] status;
   logic       last;

   modport source (output valid, output kind, output data_byte, output status,
                   output last, input ready);
   modport sink   (input valid, input kind, input data_byte, input status,
                   input last, output ready);
endinterface

`default_nettype wire

[rtl/b64d_result_queue.sv]
// Queue of result bundles that hands out one result per output transaction.
`default_nettype none

module b64d_result_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire b64d_pkg::bundle_type push_bundle,
   output logic                    full,
   output logic                    out_valid,
   output b64d_pkg::result_type    out_result,
   input  wire logic               out_ready
);

   b64d_pkg::bundle_type entries_ff [b64d_pkg::QUEUE_DEPTH];

   logic [b64d_pkg::QUEUE_ADDR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [b64d_pkg::QUEUE_ADDR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [b64d_pkg::QUEUE_COUNT_W-1:0] count_ff, count_in;
   logic [1:0]                         sub_ff, sub_in;

   b64d_pkg::bundle_type head;
   logic                 pop_result;
   logic                 pop_entry;

   localparam logic [b64d_pkg::QUEUE_ADDR_W-1:0] LAST_ADDR =
      b64d_pkg::QUEUE_ADDR_W'(b64d_pkg::QUEUE_DEPTH - 1);
   localparam logic [b64d_pkg::QUEUE_COUNT_W-1:0] FULL_COUNT =
      b64d_pkg::QUEUE_COUNT_W'(b64d_pkg::QUEUE_DEPTH);
   localparam logic [b64d_pkg::QUEUE_ADDR_W-1:0] ADDR_STEP =
      b64d_pkg::QUEUE_ADDR_W'(1);
   localparam logic [b64d_pkg::QUEUE_COUNT_W-1:0] COUNT_STEP =
      b64d_pkg::QUEUE_COUNT_W'(1);

   assign head       = entries_ff[rd_ptr_ff];
   assign full       = (count_ff == FULL_COUNT);
   assign out_valid  = (count_ff != '0);
   assign out_result = head.results[sub_ff];
   assign pop_result = out_valid && out_ready;
   assign pop_entry  = pop_result && (sub_ff == head.count - 2'd1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      sub_in    = sub_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_ADDR) ? '0 : wr_ptr_ff + ADDR_STEP;
      end
      if (pop_result) begin
         sub_in = sub_ff + 2'd1;
      end
      if (pop_entry) begin
         sub_in    = '0;
         rd_ptr_in = (rd_ptr_ff == LAST_ADDR) ? '0 : rd_ptr_ff + ADDR_STEP;
      end
      if (push && !pop_entry) begin
         count_in = count_ff + COUNT_STEP;
      end else if (!push && pop_entry) begin
         count_in = count_ff - COUNT_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sub_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sub_ff    <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_bundle;
      end
   end

endmodule

`default_nettype wire

[rtl/base64_decoder.sv]
// Top level of the streaming base64 decoder.
`default_nettype none

// Channel  Direction  Payload                              Transaction
// -------  ---------  -----------------------------------  --------------------------
// req      in         action (1), ch (8)                   one character or end mark
// rsp      out        kind (1), data_byte (8), status (2),  one data byte or status
//                     last (1)
//
// The decoder takes one input transaction per cycle while the queue is not full;
// each one updates the symbol state at once and parks its zero to three results
// as a single bundle in a four-entry queue, where the bundle is registered before
// its first result shows on rsp. The queue drains one result per cycle while
// rsp.ready is high, which sets the sustained rate when the input keeps producing
// triples. Reset is synchronous and clears the symbol state and the queue. A
// stalled rsp fills the queue, and req.ready drops only when the queue is full.
module base64_decoder (
   input wire logic   clock,
   input wire logic   reset,
   b64d_req_if.sink   req,
   b64d_rsp_if.source rsp
);

   // Symbol accumulator state, one string at a time.
   logic [17:0] symbol_bits_ff,    symbol_bits_in;
   logic [1:0]  symbol_count_ff,   symbol_count_in;
   logic        padding_seen_ff,   padding_seen_in;
   logic [1:0]  pending_status_ff, pending_status_in;

   logic                  accept;
   logic                  queue_full;
   logic                  push;
   b64d_pkg::bundle_type  bundle;
   b64d_pkg::symbol_type  sym;
   logic [23:0]           full_group;
   b64d_pkg::result_type  head_result;
   logic                  head_valid;

   assign req.ready  = !queue_full;
   assign accept     = req.valid && req.ready;
   assign sym        = b64d_pkg::symbol_lookup(req.ch);
   assign full_group = {symbol_bits_ff, sym.value};

   // Decode of one transaction: results and the next symbol state.
   always_comb begin
      symbol_bits_in    = symbol_bits_ff;
      symbol_count_in   = symbol_count_ff;
      padding_seen_in   = padding_seen_ff;
      pending_status_in = pending_status_ff;
      push              = 1'b0;
      bundle            = '0;

      if (req.action == b64d_pkg::ACTION_END) begin
         // The end mark reports the status and starts a fresh string.
         push                       = 1'b1;
         bundle.count               = 2'd1;
         bundle.results[0].kind     = b64d_pkg::KIND_STATUS;
         bundle.results[0].last     = 1'b1;
         if (padding_seen_ff) begin
            bundle.results[0].status = pending_status_ff;
         end else if (symbol_count_ff != 2'd0) begin
            bundle.results[0].status = b64d_pkg::STATUS_TRUNCATED;
         end else begin
            bundle.results[0].status = b64d_pkg::STATUS_OK;
         end
         symbol_bits_in    = '0;
         symbol_count_in   = '0;
         padding_seen_in   = 1'b0;
         pending_status_in = b64d_pkg::STATUS_OK;
      end else if (padding_seen_ff) begin
         // Everything after the padding character is ignored.
      end else if (req.ch == b64d_pkg::PAD_CHAR) begin
         padding_seen_in   = 1'b1;
         pending_status_in = b64d_pkg::STATUS_OK;
         symbol_bits_in    = '0;
         symbol_count_in   = '0;
         case (symbol_count_ff)
            2'd0: begin
               pending_status_in = b64d_pkg::STATUS_PAD_BOUNDARY;
            end
            2'd1: begin
               pending_status_in = b64d_pkg::STATUS_PAD_ONE;
            end
            2'd2: begin
               push              = 1'b1;
               bundle.count      = 2'd1;
               bundle.results[0] = b64d_pkg::data_result(symbol_bits_ff[11:4], 1'b1);
            end
            default: begin
               push              = 1'b1;
               bundle.count      = 2'd2;
               bundle.results[0] = b64d_pkg::data_result(symbol_bits_ff[17:10], 1'b0);
               bundle.results[1] = b64d_pkg::data_result(symbol_bits_ff[9:2], 1'b1);
            end
         endcase
      end else if (sym.valid) begin
         if (symbol_count_ff == 2'd3) begin
            // Fourth symbol completes a group of three bytes.
            push              = 1'b1;
            bundle.count      = 2'd3;
            bundle.results[0] = b64d_pkg::data_result(full_group[23:16], 1'b0);
            bundle.results[1] = b64d_pkg::data_result(full_group[15:8], 1'b0);
            bundle.results[2] = b64d_pkg::data_result(full_group[7:0], 1'b1);
            symbol_bits_in    = '0;
            symbol_count_in   = '0;
         end else begin
            symbol_bits_in  = full_group[17:0];
            symbol_count_in = symbol_count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_bits_ff    <= '0;
         symbol_count_ff   <= '0;
         padding_seen_ff   <= 1'b0;
         pending_status_ff <= b64d_pkg::STATUS_OK;
      end else if (accept) begin
         symbol_bits_ff    <= symbol_bits_in;
         symbol_count_ff   <= symbol_count_in;
         padding_seen_ff   <= padding_seen_in;
         pending_status_ff <= pending_status_in;
      end
   end

   // Results wait here until the downstream side takes them one by one.
   b64d_result_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (accept && push),
      .push_bundle (bundle),
      .full        (queue_full),
      .out_valid   (head_valid),
      .out_result  (head_result),
      .out_ready   (rsp.ready)
   );

   assign rsp.valid     = head_valid;
   assign rsp.kind      = head_result.kind;
   assign rsp.data_byte = head_result.data_byte;
   assign rsp.status    = head_result.status;
   assign rsp.last      = head_result.last;

endmodule

`default_nettype wire
